// ===== rtl/core/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants of the rANS bypass decoder: opcodes, command
// kinds, status codes and the command record passed from front to back.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam logic [2:0] OP_CDF   = 3'd0;
  localparam logic [2:0] OP_LEN   = 3'd1;
  localparam logic [2:0] OP_PUSH  = 3'd2;
  localparam logic [2:0] OP_START = 3'd3;
  localparam logic [2:0] OP_DEC   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;

  localparam int unsigned PREC_BITS = 16;
  localparam int unsigned NIB_BITS  = 4;
  localparam logic [3:0]  NIB_MAX   = 4'hF;
  localparam logic [63:0] LOW_BOUND = 64'h0000_0000_8000_0000;

  typedef enum logic [2:0] {
    K_CDF,
    K_LEN,
    K_PUSH,
    K_START,
    K_DEC,
    K_ZERO
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [5:0]  tab;
    logic [5:0]  pos;
    logic [16:0] cval;
    logic [6:0]  tlen;
    logic [15:0] toff;
    logic [31:0] word;
  } cmd_t;

endpackage

// ===== rtl/core/rans_bypass_decoder.sv =====
// Table writes and word pushes complete at dispatch; a stream start pops two words.
// A decode's duration grows with the table length and with the bypass nibbles read,
// set by the one-entry-per-cycle CDF search on the single table memory port.
// One command executes at a time; a two-entry queue keeps input accepting.
// Reset (synchronous, rst_n low) empties the word queue and zeroes the state;
// the CDF, length and offset tables are not cleared and must be written.
// ----------------------------------------------------------------------------
// rans_bypass_decoder
// 64-bit rANS symbol decoder with 16-bit-precision CDF tables (17-bit entries) and a bypass escape path.
// ----------------------------------------------------------------------------
module rans_bypass_decoder #(
  parameter int NUM_TABLES         = 64,
  parameter int MAX_CDF_LEN        = 64,
  parameter int QUEUE_DEPTH        = 16,
  parameter int MAX_BYPASS_NIBBLES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_opcode,
  input  logic [5:0]         in_table_index,
  input  logic               in_skip_position,
  input  logic [5:0]         in_entry_position,
  input  logic [16:0]        in_cdf_value,
  input  logic [6:0]         in_table_length,
  input  logic signed [15:0] in_symbol_offset,
  input  logic [31:0]        in_stream_word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_symbol,
  output logic [1:0]         out_status
);
  import rbd_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  rbd_front #(
    .NUM_TABLES (NUM_TABLES),
    .MAX_CDF_LEN(MAX_CDF_LEN)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_table_index   (in_table_index),
    .in_skip_position (in_skip_position),
    .in_entry_position(in_entry_position),
    .in_cdf_value     (in_cdf_value),
    .in_table_length  (in_table_length),
    .in_symbol_offset (in_symbol_offset),
    .in_stream_word   (in_stream_word),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop)
  );

  rbd_back #(
    .NUM_TABLES        (NUM_TABLES),
    .MAX_CDF_LEN       (MAX_CDF_LEN),
    .QUEUE_DEPTH       (QUEUE_DEPTH),
    .MAX_BYPASS_NIBBLES(MAX_BYPASS_NIBBLES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_symbol(out_symbol),
    .out_status(out_status)
  );

endmodule

// ===== rtl/core/rbd_front.sv =====
// ----------------------------------------------------------------------------
// rbd_front
// Accepts input transactions, classifies them into commands and holds them
// in a two-entry queue for the back end. Items that do nothing are dropped.
// ----------------------------------------------------------------------------
module rbd_front #(
  parameter int NUM_TABLES  = 64,
  parameter int MAX_CDF_LEN = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_opcode,
  input  logic [5:0]         in_table_index,
  input  logic               in_skip_position,
  input  logic [5:0]         in_entry_position,
  input  logic [16:0]        in_cdf_value,
  input  logic [6:0]         in_table_length,
  input  logic signed [15:0] in_symbol_offset,
  input  logic [31:0]        in_stream_word,
  output logic               cmd_valid,
  output rbd_pkg::cmd_t      cmd,
  input  logic               cmd_pop
);
  import rbd_pkg::*;

  cmd_t       ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       keep;
  logic       tab_ok;
  cmd_t       cls;
  logic       push;

  assign tab_ok = 32'(in_table_index) < NUM_TABLES;

  always_comb begin
    cls.tab  = in_table_index;
    cls.pos  = in_entry_position;
    cls.cval = in_cdf_value;
    cls.tlen = in_table_length;
    cls.toff = in_symbol_offset;
    cls.word = in_stream_word;
    cls.kind = K_ZERO;
    keep     = 1'b0;
    unique case (in_opcode)
      OP_CDF: begin
        cls.kind = K_CDF;
        keep     = tab_ok && (32'(in_entry_position) < MAX_CDF_LEN);
      end
      OP_LEN: begin
        cls.kind = K_LEN;
        keep     = tab_ok;
      end
      OP_PUSH: begin
        cls.kind = K_PUSH;
        keep     = 1'b1;
      end
      OP_START: begin
        cls.kind = K_START;
        keep     = 1'b1;
      end
      OP_DEC: begin
        cls.kind = (in_skip_position || !tab_ok) ? K_ZERO : K_DEC;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall && keep;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (cmd_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

// ===== rtl/core/rbd_back.sv =====
// ----------------------------------------------------------------------------
// rbd_back
// Executes commands one at a time: table writes, stream word queue, stream
// start and symbol decode with slot search, state update, renormalization
// and bypass nibble reads. Holds the result register of the output channel.
// ----------------------------------------------------------------------------
module rbd_back #(
  parameter int NUM_TABLES         = 64,
  parameter int MAX_CDF_LEN        = 64,
  parameter int QUEUE_DEPTH        = 16,
  parameter int MAX_BYPASS_NIBBLES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  rbd_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_symbol,
  output logic [1:0]         out_status
);
  import rbd_pkg::*;

  localparam int AW  = $clog2(NUM_TABLES * MAX_CDF_LEN);
  localparam int TBW = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int LW  = $clog2(MAX_CDF_LEN + 1);
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_ST_LO, S_ST_HI, S_SETUP, S_SEARCH, S_RD_S, S_RD_S1,
    S_MUL_LO, S_MUL_HI, S_RENORM, S_NIB, S_FINISH, S_OUT
  } state_t;

  state_t      st_r;
  cmd_t        cmd_r;

  logic [16:0] cdf_mem [NUM_TABLES * MAX_CDF_LEN];
  logic [6:0]  len_mem [NUM_TABLES];
  logic [15:0] off_mem [NUM_TABLES];
  logic [31:0] q_mem   [QUEUE_DEPTH];

  logic [16:0] cdf_rdata_r;
  logic [6:0]  len_q_r;
  logic [15:0] off_q_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] cdf_waddr;
  logic [TBW-1:0] tab_idx;

  logic [QW-1:0] q_head_r;
  logic [CW-1:0] q_cnt_r;
  logic [QW-1:0] q_head_inc;
  logic [QW:0]   q_tail_sum;
  logic [QW-1:0] q_tail;
  logic          q_empty;
  logic          q_push;
  logic          pop_req;
  logic [31:0]   pop_data;

  logic [63:0]   coder_r;
  logic [63:0]   acc_r;
  logic [16:0]   start_r;
  logic [16:0]   freq_r;
  logic [16:0]   freq;
  logic [40:0]   p_lo;
  logic [40:0]   p_hi;

  logic [AW-1:0] base_r;
  logic [LW-1:0] len_r;
  logic [LW-1:0] esc_r;
  logic [LW-1:0] len_c;
  logic [15:0]   cum_r;
  logic [LW-1:0] k_r;
  logic [LW-1:0] c_r;
  logic          rdv_r;
  logic [LW-1:0] s_r;

  logic          raw_phase_r;
  logic [31:0]   n_r;
  logic [31:0]   j_r;
  logic [31:0]   raw_r;
  logic          too_long_r;
  logic          under_r;
  logic [3:0]    nib_v;
  logic [63:0]   nib_shift;
  logic [63:0]   nib_next;
  logic [31:0]   cnt_sum;
  logic [15:0]   byp_half;
  logic [15:0]   val16;

  logic [15:0]   res_sym_r;
  logic [1:0]    res_st_r;
  logic          out_valid_r;
  logic [15:0]   out_symbol_r;
  logic [1:0]    out_status_r;

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_status = out_status_r;
  assign cmd_pop    = (st_r == S_IDLE) && cmd_valid;

  // Word queue bookkeeping.
  assign q_empty    = (q_cnt_r == CW'(0));
  assign pop_data   = q_empty ? 32'd0 : q_mem[q_head_r];
  assign q_head_inc = (32'(q_head_r) == QUEUE_DEPTH - 1) ? QW'(0) : q_head_r + QW'(1);
  assign q_tail_sum = (QW + 1)'(q_head_r) + (QW + 1)'(q_cnt_r);
  assign q_tail     = (32'(q_tail_sum) >= QUEUE_DEPTH) ?
                      QW'(32'(q_tail_sum) - QUEUE_DEPTH) : QW'(q_tail_sum);
  assign q_push     = (st_r == S_DISP) && (cmd_r.kind == K_PUSH) &&
                      (32'(q_cnt_r) < QUEUE_DEPTH);

  assign nib_v     = coder_r[3:0];
  assign nib_shift = coder_r >> NIB_BITS;
  assign nib_next  = (nib_shift < LOW_BOUND) ? {nib_shift[31:0], pop_data} : nib_shift;
  assign cnt_sum   = n_r + 32'(nib_v);

  always_comb begin
    case (st_r)
      S_ST_LO, S_ST_HI: pop_req = 1'b1;
      S_RENORM:         pop_req = coder_r < LOW_BOUND;
      S_NIB:            pop_req = nib_shift < LOW_BOUND;
      default:          pop_req = 1'b0;
    endcase
  end

  // Table addressing.
  assign tab_idx   = TBW'(cmd_r.tab);
  assign cdf_waddr = AW'(32'(cmd_r.tab) * MAX_CDF_LEN + 32'(cmd_r.pos));

  always_comb begin
    case (st_r)
      S_RD_S:  rd_addr = base_r + AW'(s_r);
      S_RD_S1: rd_addr = base_r + AW'(s_r) + AW'(1);
      default: rd_addr = base_r + AW'(k_r);
    endcase
  end

  always_comb begin
    if (32'(len_q_r) < 2) begin
      len_c = LW'(2);
    end else if (32'(len_q_r) > MAX_CDF_LEN) begin
      len_c = LW'(MAX_CDF_LEN);
    end else begin
      len_c = LW'(len_q_r);
    end
  end

  assign freq = cdf_rdata_r - start_r;
  assign p_lo = 41'(freq) * 41'(coder_r[39:16]);
  assign p_hi = 41'(freq_r) * 41'(coder_r[63:40]);

  // An odd raw value maps to the complement of its bits 16:1, an even one to those bits above the escape.
  assign byp_half = raw_r[16:1];
  always_comb begin
    if (s_r == esc_r) begin
      val16 = raw_r[0] ? ~byp_half : byp_half + 16'(esc_r);
    end else begin
      val16 = 16'(s_r);
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_DISP && cmd_r.kind == K_CDF) begin
      cdf_mem[cdf_waddr] <= cmd_r.cval;
    end
    cdf_rdata_r <= cdf_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (st_r == S_DISP && cmd_r.kind == K_LEN) begin
      len_mem[tab_idx] <= cmd_r.tlen;
      off_mem[tab_idx] <= cmd_r.toff;
    end
    len_q_r <= len_mem[tab_idx];
    off_q_r <= off_mem[tab_idx];
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_tail] <= cmd_r.word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      q_head_r    <= QW'(0);
      q_cnt_r     <= CW'(0);
      coder_r     <= 64'd0;
    end else begin
      if (out_valid_r && !out_stall && st_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      if (pop_req) begin
        under_r <= under_r | q_empty;
        if (!q_empty) begin
          q_head_r <= q_head_inc;
        end
      end
      if (q_push) begin
        q_cnt_r <= q_cnt_r + CW'(1);
      end else if (pop_req && !q_empty) begin
        q_cnt_r <= q_cnt_r - CW'(1);
      end

      unique case (st_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            st_r  <= S_DISP;
          end
        end
        S_DISP: begin
          under_r    <= 1'b0;
          too_long_r <= 1'b0;
          case (cmd_r.kind)
            K_START: st_r <= S_ST_LO;
            K_DEC:   st_r <= S_SETUP;
            K_ZERO: begin
              res_sym_r <= 16'd0;
              res_st_r  <= ST_OK;
              st_r      <= S_OUT;
            end
            default: st_r <= S_IDLE;
          endcase
        end
        S_ST_LO: begin
          coder_r[31:0] <= pop_data;
          st_r          <= S_ST_HI;
        end
        S_ST_HI: begin
          coder_r[63:32] <= pop_data;
          res_sym_r      <= 16'd0;
          res_st_r       <= (under_r || q_empty) ? ST_UNDER : ST_OK;
          st_r           <= S_OUT;
        end
        S_SETUP: begin
          len_r  <= len_c;
          esc_r  <= len_c - LW'(2);
          cum_r  <= coder_r[15:0];
          base_r <= AW'(32'(cmd_r.tab) * MAX_CDF_LEN);
          k_r    <= LW'(0);
          rdv_r  <= 1'b0;
          st_r   <= S_SEARCH;
        end
        S_SEARCH: begin
          // Reads are issued one per cycle; each compare follows in the cycle after its read.
          if (k_r < len_r) begin
            k_r <= k_r + LW'(1);
          end
          rdv_r <= k_r < len_r;
          c_r   <= k_r;
          if (rdv_r) begin
            if (cdf_rdata_r > {1'b0, cum_r}) begin
              s_r  <= (c_r == LW'(0)) ? LW'(0) : c_r - LW'(1);
              st_r <= S_RD_S;
            end else if (c_r + LW'(1) == len_r) begin
              s_r  <= esc_r;
              st_r <= S_RD_S;
            end
          end
        end
        S_RD_S: begin
          st_r <= S_RD_S1;
        end
        S_RD_S1: begin
          start_r <= cdf_rdata_r;
          st_r    <= S_MUL_LO;
        end
        S_MUL_LO: begin
          freq_r <= freq;
          acc_r  <= 64'(p_lo) + 64'(coder_r[15:0]) - 64'(start_r);
          st_r   <= S_MUL_HI;
        end
        S_MUL_HI: begin
          coder_r <= acc_r + {p_hi[39:0], 24'd0};
          st_r    <= S_RENORM;
        end
        S_RENORM: begin
          if (coder_r < LOW_BOUND) begin
            coder_r <= {coder_r[31:0], pop_data};
          end
          raw_phase_r <= 1'b0;
          n_r         <= 32'd0;
          raw_r       <= 32'd0;
          st_r        <= (s_r == esc_r) ? S_NIB : S_FINISH;
        end
        S_NIB: begin
          coder_r <= nib_next;
          if (!raw_phase_r) begin
            n_r <= cnt_sum;
            if (nib_v != NIB_MAX) begin
              raw_phase_r <= 1'b1;
              j_r         <= 32'd0;
              if (cnt_sum == 32'd0) begin
                st_r <= S_FINISH;
              end
            end
          end else begin
            if (j_r < MAX_BYPASS_NIBBLES) begin
              raw_r[{j_r[2:0], 2'b00} +: 4] <= nib_v;
            end else begin
              too_long_r <= 1'b1;
            end
            j_r <= j_r + 32'd1;
            if (j_r + 32'd1 == n_r) begin
              st_r <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          res_sym_r <= val16 + off_q_r;
          res_st_r  <= under_r ? ST_UNDER : (too_long_r ? ST_LONG : ST_OK);
          st_r      <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_symbol_r <= res_sym_r;
            out_status_r <= res_st_r;
            st_r         <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/rbd_checker.sv =====
// ----------------------------------------------------------------------------
// rbd_checker
// Port-level checks of the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_symbol,
  input logic [1:0]  out_status
);

  // A result held by the receiver keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_symbol) && $stable(out_status))
    else $error("result changed while stalled");

  // No result comes out in the cycle after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

endmodule

bind rans_bypass_decoder rbd_checker u_rbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_symbol(out_symbol),
  .out_status(out_status)
);
